FILE: sv/ssr_pkg.sv
`timescale 1ns / 1ps
package ssr_pkg;

  localparam int IW = 24;
  localparam int COMB_LINE_MAX = 2048;
  localparam int ALLPASS_LINE_MAX = 1024;
  localparam int CAW = 14;
  localparam int AAW = 12;
  localparam int CPW = 11;
  localparam int APW = 10;
  localparam int SPREAD = 23;

  localparam logic [1:0] REG_ROOM = 2'd0;
  localparam logic [1:0] REG_DAMP = 2'd1;
  localparam logic [1:0] REG_WET  = 2'd2;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               block_end_out;
  } out_item_t;

  typedef struct packed {
    logic [16:0] fb;
    logic [16:0] d;
    logic [15:0] wet;
  } coef_t;

  function automatic logic [CPW-1:0] comb_len(input logic [1:0] c, input logic ch);
    logic [CPW-1:0] b;
    case (c)
      2'd0: b = CPW'(1557);
      2'd1: b = CPW'(1617);
      2'd2: b = CPW'(1491);
      default: b = CPW'(1422);
    endcase
    return ch ? b + CPW'(SPREAD) : b;
  endfunction

  function automatic logic [APW-1:0] ap_len(input logic a);
    return a ? APW'(441) : APW'(556);
  endfunction

  function automatic logic signed [IW-1:0] sat_iw(input logic signed [IW+1:0] v);
    if (v > $signed((IW+2)'((1 << (IW-1)) - 1))) return {1'b0, {(IW-1){1'b1}}};
    if (v < -$signed((IW+2)'(1 << (IW-1)))) return {1'b1, {(IW-1){1'b0}}};
    return v[IW-1:0];
  endfunction

endpackage

FILE: sv/ssr_ram.sv
`timescale 1ns / 1ps
module ssr_ram #(
  parameter int AW = 10,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/ssr_core.sv
`timescale 1ns / 1ps
module ssr_core
  import ssr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  coef_t     coef,
  input  logic      start,
  input  in_item_t  item,
  input  logic      hold,
  output logic      done,
  output out_item_t result,
  output logic      clearing
);
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CREAD, S_CCALC, S_CWRITE, S_AREAD, S_AWRITE, S_MIX
  } state_t;

  state_t state;
  logic ch;
  logic [1:0] idx;
  logic [CAW-1:0] clr;
  logic [CPW-1:0] cpos [0:7];
  logic [APW-1:0] apos [0:3];
  logic signed [IW-1:0] dmem [0:7];
  logic signed [IW+1:0] sum;
  logic signed [IW-1:0] acc, y, filt;
  logic signed [15:0] xin;
  logic signed [15:0] lres;
  in_item_t cur;

  // memories
  logic c_we, a_we;
  logic [CAW-1:0] c_addr, c_waddr;
  logic [AAW-1:0] a_addr, a_waddr;
  logic [IW-1:0] c_wdata, a_wdata, c_rdata, a_rdata;

  logic [2:0] cline;
  logic [1:0] aline;
  assign cline = {ch, idx};
  assign aline = {ch, idx[0]};
  assign c_addr = {cline, cpos[cline]};
  assign a_addr = {aline, apos[aline]};

  ssr_ram #(.AW(CAW), .DW(IW)) u_comb (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_addr), .rdata(c_rdata)
  );
  ssr_ram #(.AW(AAW), .DW(IW)) u_ap (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_addr), .rdata(a_rdata)
  );

  // datapath
  logic signed [IW-1:0] x;
  logic signed [IW+18:0] pf, pc, pm;
  logic signed [IW+1:0] cw;
  logic signed [IW-1:0] b;
  logic signed [IW+1:0] ap_out, ap_wr;
  logic signed [IW+19:0] mixr;
  logic signed [15:0] mo;

  // comb tap straight from the read port
  assign y = c_rdata;
  assign x = {xin, {(IW-16){1'b0}}};
  assign pf = $signed({1'b0, 17'h10000 - coef.d}) * y
              + $signed({1'b0, coef.d}) * dmem[cline] + (IW+19)'(32768);
  assign pc = $signed({1'b0, coef.fb}) * filt + (IW+19)'(32768);
  assign pm = '0;
  assign cw = (IW+2)'(x) + (IW+2)'(pc >>> 16);
  assign b = a_rdata;
  assign ap_out = (IW+2)'(b) - (IW+2)'(acc);
  assign ap_wr = (IW+2)'(acc) + (IW+2)'(b >>> 1);
  assign mixr = (IW+20)'($signed({1'b0, 17'h10000 - {1'b0, coef.wet}}) * x)
              + (IW+20)'($signed({1'b0, coef.wet}) * acc)
              + (IW+20)'(1 << (IW-1));
  always_comb begin
    logic signed [19:0] r;
    r = 20'(mixr >>> IW);
    if (r > 20'sd32767) mo = 16'sh7fff;
    else if (r < -20'sd32768) mo = 16'sh8000;
    else mo = r[15:0];
  end

  always_comb begin
    c_we = 1'b0; c_waddr = c_addr; c_wdata = sat_iw(cw);
    a_we = 1'b0; a_waddr = a_addr; a_wdata = sat_iw(ap_wr);
    if (state == S_CLEAR) begin
      c_we = 1'b1; c_waddr = clr; c_wdata = '0;
      a_we = 1'b1; a_waddr = clr[AAW-1:0]; a_wdata = '0;
    end else if (state == S_CWRITE) begin
      c_we = 1'b1;
    end else if (state == S_AWRITE) begin
      a_we = 1'b1;
    end
  end

  assign clearing = (state == S_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      done <= 1'b0;
      ch <= 1'b0;
      idx <= '0;
      for (int i = 0; i < 8; i++) begin cpos[i] <= '0; dmem[i] <= '0; end
      for (int i = 0; i < 4; i++) apos[i] <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (&clr) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          cur <= item; xin <= item.left_sample; ch <= 1'b0; idx <= '0;
          sum <= '0; state <= S_CREAD;
        end
        S_CREAD: state <= S_CCALC;
        // tap is on the read port: damping filter and comb sum
        S_CCALC: begin
          filt <= sat_iw((IW+2)'(pf >>> 16));
          sum <= sum + (IW+2)'(y);
          state <= S_CWRITE;
        end
        // feedback write-back, filter memory, position
        S_CWRITE: begin
          dmem[cline] <= filt;
          cpos[cline] <= (cpos[cline] == comb_len(idx, ch) - 1'b1) ? '0 : cpos[cline] + 1'b1;
          if (idx == 2'd3) begin
            acc <= IW'(sum >>> 2);
            idx <= '0; state <= S_AREAD;
          end else begin
            idx <= idx + 1'b1; state <= S_CREAD;
          end
        end
        S_AREAD: state <= S_AWRITE;
        S_AWRITE: begin
          acc <= sat_iw(ap_out);
          apos[aline] <= (apos[aline] == ap_len(idx[0]) - 1'b1) ? '0 : apos[aline] + 1'b1;
          if (idx[0]) state <= S_MIX;
          else begin idx <= 2'd1; state <= S_AREAD; end
        end
        S_MIX: begin
          if (!ch) begin
            lres <= mo; ch <= 1'b1; idx <= '0; xin <= cur.right_sample;
            sum <= '0; state <= S_CREAD;
          end else if (!hold) begin
            result.left_out <= lres; result.right_out <= mo;
            result.block_end_out <= cur.block_end;
            done <= 1'b1; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_no_start_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !done) else $error("done during clear");
  a_idx_ap: assert property (@(posedge clk) disable iff (rst)
    (state == S_AREAD) |-> (idx == 2'd0 || idx == 2'd1)) else $error("bad allpass idx");
`endif
endmodule

FILE: sv/stereo_schroeder_reverb_top.sv
`timescale 1ns / 1ps
// Stereo four-comb, two-allpass reverb. After reset the delay memories are
// cleared, during which no item is taken. Each frame is then processed step
// by step: each of eight combs steps through read, filter and write-back on
// the shared comb delay memory, and each of four allpasses through read and
// write-back on the shared allpass delay memory, plus a mix step per channel.
// The next item is taken only once the core has finished the previous one. A
// finished result waits in an output register; while it waits, the next frame
// is computed and held at its last mix step until the output register is free.
module stereo_schroeder_reverb_top
  import ssr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] room, damp, wet;
  coef_t coef;
  logic busy, done, clearing, start, out_hold;
  out_item_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      room <= 16'd32768; damp <= 16'd32768; wet <= 16'd13107;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROOM: room <= cfg_data;
        REG_DAMP: damp <= cfg_data;
        REG_WET:  wet <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficients, registered
  logic [31:0] pr, pd;
  assign pr = 32'(room) * 32'd45875 + 32'd32768;
  assign pd = 32'(damp) * 32'd26214 + 32'd32768;
  always_ff @(posedge clk) begin
    coef.fb <= 17'd18350 + 17'(pr[31:16]);
    coef.d <= 17'(pd[31:16]);
    coef.wet <= wet;
  end

  assign in_stall = busy || clearing;
  assign start = in_valid && !in_stall;
  // core may not finish while the output register still holds an item
  assign out_hold = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (start) busy <= 1'b1;
      if (done) begin busy <= 1'b0; out_valid <= 1'b1; out_data <= res; end
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  ssr_core u_core (
    .clk, .rst, .coef, .start, .item(in_data), .hold(out_hold), .done, .result(res),
    .clearing
  );
endmodule
